// ===== sv/soc_pkg.sv =====
// shared types and constants of the segment overlap checker
package soc_pkg;

    localparam int ADDR_W       = 16;
    localparam int TAG_W        = 8;
    localparam int KIND_W       = 3;
    localparam int CNT_W        = 5;
    localparam int MAX_SEGS_DEF = 8;

    localparam int S_DATA_BITS  = 2 * ADDR_W + TAG_W;
    localparam int S_TDATA_W    = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS  = 2 * TAG_W + 5 * ADDR_W + CNT_W;
    localparam int M_TDATA_W    = ((M_DATA_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] end_addr;
        logic [TAG_W-1:0]  tag;
    } seg_t;

    typedef struct packed {
        logic ins;
        logic rot;
        logic clr;
    } cell_ctl_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRAP    = 3'd0,
        KIND_OVERLAP = 3'd1,
        KIND_HEADER  = 3'd2,
        KIND_SUGGEST = 3'd3,
        KIND_DONE    = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [TAG_W-1:0]  tag_a;
        logic [TAG_W-1:0]  tag_b;
        logic [ADDR_W-1:0] start_a;
        logic [ADDR_W-1:0] end_a;
        logic [ADDR_W-1:0] start_b;
        logic [ADDR_W-1:0] end_b;
        logic [ADDR_W-1:0] suggested_addr;
        logic [CNT_W-1:0]  issue_count;
        logic              final_res;
    } res_t;

endpackage

// ===== sv/soc_cell.sv =====
// one cell of the segment ring: sorted insertion and rotation
module soc_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  soc_pkg::cell_ctl_t   ctl,
    input  soc_pkg::seg_t        new_seg,
    input  soc_pkg::seg_t        left_seg,
    input  logic                 left_valid,
    input  logic                 left_gt,
    input  soc_pkg::seg_t        right_seg,
    input  logic                 right_valid,
    output soc_pkg::seg_t        seg,
    output logic                 valid,
    output logic                 gt
);

    soc_pkg::seg_t seg_reg, seg_next;
    logic          valid_reg, valid_next;
    logic          load;

    assign gt   = valid_reg && (seg_reg.start_addr > new_seg.start_addr);
    assign load = ctl.ins && (gt || (!valid_reg && left_valid));

    always_comb begin
        seg_next   = seg_reg;
        valid_next = valid_reg;
        priority if (ctl.clr) begin
            valid_next = 1'b0;
        end else if (ctl.rot) begin
            seg_next   = right_seg;
            valid_next = right_valid;
        end else if (load) begin
            seg_next   = left_gt ? left_seg : new_seg;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        seg_reg <= seg_next;
    end

    assign seg   = seg_reg;
    assign valid = valid_reg;

endmodule

// ===== sv/soc_seq.sv =====
// sequencer: walks the rotating ring and drives the result register
module soc_seq #(
    parameter int MAX_SEGS = soc_pkg::MAX_SEGS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_fire,
    input  logic                          in_last,
    input  logic                          keep,
    input  soc_pkg::seg_t                 head_seg,
    input  logic                          head_valid,
    input  logic                          two_valid,
    output logic                          in_ready,
    output soc_pkg::cell_ctl_t            ctl,
    output logic                          m_valid,
    input  logic                          m_ready,
    output soc_pkg::res_t                 res
);

    localparam int K_W = $clog2(MAX_SEGS + 1);
    localparam int I_W = $clog2(MAX_SEGS);
    localparam int S_W = $clog2(2 * MAX_SEGS);

    typedef enum logic [6:0] {
        ST_LOAD  = 7'b0000001,
        ST_WRAP  = 7'b0000010,
        ST_PIVOT = 7'b0000100,
        ST_SCAN  = 7'b0001000,
        ST_HDR   = 7'b0010000,
        ST_SUG   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t                         state_reg, state_next;
    logic [K_W-1:0]                 k_reg, k_next;
    logic [I_W-1:0]                 i_reg, i_next;
    logic [soc_pkg::CNT_W-1:0]      issues_reg, issues_next;
    logic [soc_pkg::ADDR_W-1:0]     addr_reg, addr_next;
    soc_pkg::seg_t                  piv_reg, piv_next;
    logic                           piv_valid_reg, piv_valid_next;
    logic                           m_valid_reg, m_valid_next;
    soc_pkg::res_t                  res_reg, res_next;
    logic                           step_ok, emit, head_wrap, piv_wrap, in_range;

    assign step_ok   = !m_valid_reg || m_ready;
    assign head_wrap = head_seg.end_addr < head_seg.start_addr;
    assign piv_wrap  = piv_reg.end_addr < piv_reg.start_addr;
    assign in_range  = (S_W'(i_reg) + S_W'(k_reg)) < S_W'(MAX_SEGS);
    assign in_ready  = (state_reg == ST_LOAD);

    always_comb begin
        state_next     = state_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        issues_next    = issues_reg;
        addr_next      = addr_reg;
        piv_next       = piv_reg;
        piv_valid_next = piv_valid_reg;
        res_next       = '0;
        emit           = 1'b0;
        ctl.ins        = in_fire && keep;
        ctl.rot        = 1'b0;
        ctl.clr        = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                if (in_fire && in_last) begin
                    state_next  = ST_WRAP;
                    k_next      = '0;
                    issues_next = '0;
                end
            end
            ST_WRAP: begin
                if (k_reg == '0 && !two_valid) begin
                    state_next = ST_DONE;
                end else if (step_ok) begin
                    if (head_valid && head_wrap) begin
                        emit             = 1'b1;
                        res_next.kind    = soc_pkg::KIND_WRAP;
                        res_next.tag_a   = head_seg.tag;
                        res_next.start_a = head_seg.start_addr;
                        res_next.end_a   = head_seg.end_addr;
                        issues_next      = issues_reg + 1'b1;
                    end
                    ctl.rot = 1'b1;
                    k_next  = k_reg + 1'b1;
                    if (k_reg == K_W'(MAX_SEGS - 1)) begin
                        state_next = ST_PIVOT;
                        i_next     = '0;
                    end
                end
            end
            ST_PIVOT: begin
                piv_next       = head_seg;
                piv_valid_next = head_valid;
                ctl.rot        = 1'b1;
                k_next         = K_W'(1);
                state_next     = ST_SCAN;
            end
            ST_SCAN: begin
                if (step_ok) begin
                    if (piv_valid_reg && !piv_wrap && head_valid && !head_wrap && in_range
                        && (head_seg.start_addr < piv_reg.end_addr)) begin
                        emit             = 1'b1;
                        res_next.kind    = soc_pkg::KIND_OVERLAP;
                        res_next.tag_a   = piv_reg.tag;
                        res_next.start_a = piv_reg.start_addr;
                        res_next.end_a   = piv_reg.end_addr;
                        res_next.tag_b   = head_seg.tag;
                        res_next.start_b = head_seg.start_addr;
                        res_next.end_b   = head_seg.end_addr;
                        issues_next      = issues_reg + 1'b1;
                    end
                    ctl.rot = 1'b1;
                    if (k_reg == K_W'(MAX_SEGS)) begin
                        if (i_reg == I_W'(MAX_SEGS - 1)) begin
                            state_next = (issues_reg != '0) ? ST_HDR : ST_DONE;
                        end else begin
                            i_next     = i_reg + 1'b1;
                            state_next = ST_PIVOT;
                        end
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            ST_HDR: begin
                if (step_ok) begin
                    emit          = 1'b1;
                    res_next.kind = soc_pkg::KIND_HEADER;
                    addr_next     = head_seg.start_addr;
                    k_next        = '0;
                    state_next    = ST_SUG;
                end
            end
            ST_SUG: begin
                if (step_ok) begin
                    if (head_valid && !head_wrap) begin
                        emit                    = 1'b1;
                        res_next.kind           = soc_pkg::KIND_SUGGEST;
                        res_next.tag_a          = head_seg.tag;
                        res_next.start_a        = head_seg.start_addr;
                        res_next.end_a          = head_seg.end_addr;
                        res_next.suggested_addr = addr_reg;
                        addr_next = addr_reg + (head_seg.end_addr - head_seg.start_addr);
                    end
                    ctl.rot = 1'b1;
                    k_next  = k_reg + 1'b1;
                    if (k_reg == K_W'(MAX_SEGS - 1)) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (step_ok) begin
                    emit                 = 1'b1;
                    res_next.kind        = soc_pkg::KIND_DONE;
                    res_next.issue_count = issues_reg;
                    res_next.final_res   = 1'b1;
                    ctl.clr              = 1'b1;
                    state_next           = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
        m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg         <= k_next;
        i_reg         <= i_next;
        issues_reg    <= issues_next;
        addr_reg      <= addr_next;
        piv_reg       <= piv_next;
        piv_valid_reg <= piv_valid_next;
        if (emit) begin
            res_reg <= res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign res     = res_reg;

endmodule

// ===== sv/segment_overlap_checker_top.sv =====
// top level of the segment overlap checker: ring of cells and sequencer
// Segments stream in one per cycle and are placed in start order by a ring of
// MAX_SEGS cells, each comparing its own start against the incoming one. On
// the transaction marked tlast the ring rotates through the cells to find
// wraps, overlapping pairs and, when issues exist, one header plus
// suggestions, then one done result; a stalled result output holds the walk.
// With fewer than two kept segments the batch ends with the done result right
// away. Input is not taken during the walk.
module segment_overlap_checker_top #(
    parameter int MAX_SEGS = soc_pkg::MAX_SEGS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // start_addr, end_addr, segment_tag
    input  logic [soc_pkg::S_TDATA_W-1:0]   s_tdata,
    // skip
    input  logic [0:0]                      s_tuser,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tag_a, tag_b, start_a, end_a, start_b, end_b, suggested_addr, issue_count
    output logic [soc_pkg::M_TDATA_W-1:0]   m_tdata,
    // kind
    output logic [soc_pkg::KIND_W-1:0]      m_tuser,
    output logic                            m_tlast
);

    soc_pkg::seg_t      new_seg;
    soc_pkg::seg_t      seg_w   [MAX_SEGS];
    logic [MAX_SEGS-1:0] valid_w;
    logic [MAX_SEGS-1:0] gt_w;
    soc_pkg::cell_ctl_t ctl;
    soc_pkg::res_t      res;
    logic               in_fire, keep;

    assign new_seg.start_addr = s_tdata[soc_pkg::ADDR_W-1:0];
    assign new_seg.end_addr   = s_tdata[2*soc_pkg::ADDR_W-1:soc_pkg::ADDR_W];
    assign new_seg.tag        = s_tdata[soc_pkg::S_DATA_BITS-1:2*soc_pkg::ADDR_W];

    assign in_fire = s_tvalid && s_tready;
    assign keep    = !s_tuser[0] && (new_seg.start_addr != new_seg.end_addr)
                     && !valid_w[MAX_SEGS-1];

    for (genvar g = 0; g < MAX_SEGS; g++) begin : g_cell
        if (g == 0) begin : g_first
            soc_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctl         (ctl),
                .new_seg     (new_seg),
                .left_seg    (new_seg),
                .left_valid  (1'b1),
                .left_gt     (1'b0),
                .right_seg   (seg_w[1]),
                .right_valid (valid_w[1]),
                .seg         (seg_w[0]),
                .valid       (valid_w[0]),
                .gt          (gt_w[0])
            );
        end else begin : g_rest
            soc_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctl         (ctl),
                .new_seg     (new_seg),
                .left_seg    (seg_w[g-1]),
                .left_valid  (valid_w[g-1]),
                .left_gt     (gt_w[g-1]),
                .right_seg   (seg_w[(g+1) % MAX_SEGS]),
                .right_valid (valid_w[(g+1) % MAX_SEGS]),
                .seg         (seg_w[g]),
                .valid       (valid_w[g]),
                .gt          (gt_w[g])
            );
        end
    end

    soc_seq #(
        .MAX_SEGS (MAX_SEGS)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .in_last    (s_tlast),
        .keep       (keep),
        .head_seg   (seg_w[0]),
        .head_valid (valid_w[0]),
        .two_valid  (valid_w[1]),
        .in_ready   (s_tready),
        .ctl        (ctl),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .res        (res)
    );

    assign m_tdata = {{(soc_pkg::M_TDATA_W - soc_pkg::M_DATA_BITS){1'b0}},
                      res.issue_count, res.suggested_addr, res.end_b, res.start_b,
                      res.end_a, res.start_a, res.tag_b, res.tag_a};
    assign m_tuser = res.kind;
    assign m_tlast = res.final_res;

endmodule
